// ===== rtl/cts_pkg.sv =====
package cts_pkg;

  // Operation characters of the CIGAR text.
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Operation codes carried in the low nibble of a unit.
  localparam logic [3:0] CODE_M     = 4'h0;
  localparam logic [3:0] CODE_I     = 4'h1;
  localparam logic [3:0] CODE_D     = 4'h2;
  localparam logic [3:0] CODE_EQ    = 4'h7;
  localparam logic [3:0] CODE_X     = 4'h8;
  localparam logic [3:0] CODE_OTHER = 4'hF;

  // Output queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // One result item.
  typedef struct packed {
    logic [31:0] cigar_unit;
    logic        part_select;
    logic        unit_valid;
    logic        string_end;
  } result_t;

  // Results produced by one input byte, pushed together into the queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic logic [3:0] op_code(input logic [7:0] c);
    logic [3:0] code;
    case (c)
      CHAR_M:  code = CODE_M;
      CHAR_I:  code = CODE_I;
      CHAR_D:  code = CODE_D;
      CHAR_EQ: code = CODE_EQ;
      CHAR_X:  code = CODE_X;
      default: code = CODE_OTHER;
    endcase
    return code;
  endfunction

  function automatic logic [31:0] pack_unit(input logic [31:0] len, input logic [3:0] code);
    return {len[27:0], code};
  endfunction

endpackage

// ===== rtl/cts_in_if.sv =====
interface cts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source(output valid, output text_char, output last_char, input ready);
  modport sink(input valid, input text_char, input last_char, output ready);
endinterface

// ===== rtl/cts_out_if.sv =====
interface cts_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cigar_unit;
  logic        part_select;
  logic        unit_valid;
  logic        string_end;

  modport source(output valid, output cigar_unit, output part_select,
                 output unit_valid, output string_end, input ready);
  modport sink(input valid, input cigar_unit, input part_select,
               input unit_valid, input string_end, output ready);
endinterface

// ===== rtl/cts_cfg_if.sv =====
interface cts_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] ref_target;

  modport source(output valid, output ref_target, input ready);
  modport sink(input valid, input ref_target, output ready);
endinterface

// ===== rtl/cigar_text_splitter.sv =====
// CIGAR text splitter. Takes a CIGAR string one byte per request on in_if
// (last_char marks the final byte) and returns packed units on out_if,
// each tagged with the part it belongs to: the first part runs until the
// reference length consumed reaches the target length; the user must see it
// written on cfg_if only while the block is idle, which the block does not
// enforce. An operation that crosses the target comes out as two units. A
// byte is accepted every clock cycle; its results, none, one or two, are
// registered into a four-entry output queue that drains one result per cycle
// while out_if is ready. Input is held off only while the queue lacks room
// for two results.
module cigar_text_splitter (
  input  logic      clk,
  input  logic      rst_n,
  cts_in_if.sink    in_if,
  cts_out_if.source out_if,
  cts_cfg_if.sink   cfg_if
);
  import cts_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_char_r;
  logic        in_last_r;
  logic [31:0] target_r;
  logic        room;
  logic        proc;
  push_t       push;

  assign proc         = in_vld_r && room;
  assign in_if.ready  = !in_vld_r || proc;
  assign cfg_if.ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_char_r <= in_if.text_char;
      in_last_r <= in_if.last_char;
    end
  end

  // Target length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_if.valid) begin
      target_r <= cfg_if.ref_target;
    end
  end

  cts_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (proc),
    .text_char  (in_char_r),
    .last_char  (in_last_r),
    .ref_target (target_r),
    .push       (push)
  );

  cts_out_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (proc),
    .push    (push),
    .room    (room),
    .out_if  (out_if)
  );

endmodule

// ===== rtl/cts_core.sv =====
module cts_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [7:0]    text_char,
  input  logic          last_char,
  input  logic [31:0]   ref_target,
  output cts_pkg::push_t push
);
  import cts_pkg::*;

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] cons_r, cons_nxt;
  logic        second_r, second_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic [3:0]  code;
  logic [31:0] ref_len;
  logic [32:0] sum;
  logic [31:0] head;
  logic [31:0] tail;

  assign is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
  assign digit    = 4'(text_char - CHAR_ZERO);
  assign code     = op_code(text_char);
  assign ref_len  = (text_char == CHAR_I) ? 32'd0 : acc_r;
  assign sum      = {1'b0, cons_r} + {1'b0, ref_len};
  assign head     = ref_target - cons_r;
  assign tail     = acc_r - head;

  // Result and next state for the byte in the input register.
  always_comb begin
    push       = '0;
    acc_nxt    = acc_r;
    cons_nxt   = cons_r;
    second_nxt = second_r;
    if (is_digit) begin
      acc_nxt = (acc_r << 3) + (acc_r << 1) + {28'd0, digit};
      if (last_char) begin
        push.count           = 2'd1;
        push.res0.string_end = 1'b1;
      end
    end else begin
      acc_nxt = '0;
      if (second_r || (cons_r >= ref_target)) begin
        // Target already reached: the whole operation goes to the second part.
        second_nxt            = 1'b1;
        push.count            = 2'd1;
        push.res0.cigar_unit  = pack_unit(acc_r, code);
        push.res0.part_select = 1'b1;
        push.res0.unit_valid  = 1'b1;
      end else if (sum <= {1'b0, ref_target}) begin
        // Fits within the first part.
        push.count            = 2'd1;
        push.res0.cigar_unit  = pack_unit(acc_r, code);
        push.res0.unit_valid  = 1'b1;
        cons_nxt              = sum[31:0];
        second_nxt            = (sum >= {1'b0, ref_target});
      end else begin
        // Operation crosses the target and is cut in two.
        push.count            = 2'd2;
        push.res0.cigar_unit  = pack_unit(head, code);
        push.res0.unit_valid  = 1'b1;
        push.res1.cigar_unit  = pack_unit(tail, code);
        push.res1.part_select = 1'b1;
        push.res1.unit_valid  = 1'b1;
        cons_nxt              = ref_target;
        second_nxt            = 1'b1;
      end
      if (last_char) begin
        if (push.count == 2'd2) begin
          push.res1.string_end = 1'b1;
        end else begin
          push.res0.string_end = 1'b1;
        end
      end
    end
    // The end of a string clears all per-string state.
    if (last_char) begin
      acc_nxt    = '0;
      cons_nxt   = '0;
      second_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cons_r   <= '0;
      second_r <= 1'b0;
    end else if (en) begin
      acc_r    <= acc_nxt;
      cons_r   <= cons_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== rtl/cts_out_queue.sv =====
module cts_out_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_en,
  input  cts_pkg::push_t push,
  output logic           room,
  cts_out_if.source      out_if
);
  import cts_pkg::*;

  result_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;
  logic                  pop;
  logic [QUEUE_AW:0]     push_n;
  logic [QUEUE_AW-1:0]   wr_ptr_1;

  // Room for the largest group of results one byte can cause.
  assign room     = (count_r <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
  assign pop      = out_if.valid && out_if.ready;
  assign push_n   = push_en ? (QUEUE_AW+1)'(push.count) : '0;
  assign wr_ptr_1 = wr_ptr_r + 1'b1;

  assign out_if.valid       = (count_r != '0);
  assign out_if.cigar_unit  = mem_r[rd_ptr_r].cigar_unit;
  assign out_if.part_select = mem_r[rd_ptr_r].part_select;
  assign out_if.unit_valid  = mem_r[rd_ptr_r].unit_valid;
  assign out_if.string_end  = mem_r[rd_ptr_r].string_end;

  // Storage for queued results.
  always_ff @(posedge clk) begin
    if (push_en && (push.count != 2'd0)) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push_en && (push.count == 2'd2)) begin
      mem_r[wr_ptr_1] <= push.res1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_n[QUEUE_AW-1:0];
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + push_n - (QUEUE_AW+1)'(pop);
    end
  end

endmodule
